// File: rtl/jspc_pkg.sv
// ----------------------------------------------------------------------------
// jspc_pkg
// Shared constants for the game-pad serial port controller.
// ----------------------------------------------------------------------------
`default_nettype none
package jspc_pkg;
    localparam int RxDepth  = 16;
    localparam int RxIdxW   = $clog2(RxDepth);
    localparam int RxCntW   = $clog2(RxDepth + 1);

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_BTN   = 2'd3;

    localparam logic [3:0] OFF_DATA = 4'd0;
    localparam logic [3:0] OFF_STAT = 4'd4;
    localparam logic [3:0] OFF_MODE = 4'd8;
    localparam logic [3:0] OFF_CTRL = 4'd10;
    localparam logic [3:0] OFF_BAUD = 4'd14;

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_SESSION    = 3'd1;
    localparam logic [2:0] ST_START_SEND = 3'd2;
    localparam logic [2:0] ST_SENDING    = 3'd3;
    localparam logic [2:0] ST_START_RECV = 3'd4;
    localparam logic [2:0] ST_END_RECV   = 3'd5;

    localparam logic [10:0] F_TXRDY1 = 11'h001;
    localparam logic [10:0] F_RXRDY  = 11'h002;
    localparam logic [10:0] F_TXRDY2 = 11'h004;
    localparam logic [10:0] F_PARITY = 11'h008;
    localparam logic [10:0] F_ACKLVL = 11'h080;
    localparam logic [10:0] F_IRQ    = 11'h200;

    localparam logic       CFG_BYTE_DUR = 1'b0;
    localparam logic       CFG_ACK_LEN  = 1'b1;
endpackage
`default_nettype wire

// File: rtl/joypad_serial_port_controller.sv
// Each accepted item's result lands in the output register on the clock edge that accepts it.
// Throughput: one item per cycle while i_ready does not hold the output; the whole update is one pass of logic.
// Reset: synchronous, active low; restores all registers but the output data registers, empties the queue.
// The queue store itself is not cleared; only written entries are read.
// ----------------------------------------------------------------------------
// joypad_serial_port_controller
// Serial game-pad port with bus registers, transfer machine and receive queue.
// ----------------------------------------------------------------------------
`default_nettype none
module joypad_serial_port_controller (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [3:0]  i_reg_offset,
    input  wire logic [15:0] i_write_data,
    input  wire logic        i_pad_index,
    input  wire logic [3:0]  i_button_bit,
    input  wire logic        i_pressed,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_read_data,
    output logic             o_access_error,
    output logic             o_irq_pulse,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import jspc_pkg::*;

    logic [15:0] r_byte_dur, r_ack_len;
    logic [2:0]  r_state, n_state;
    logic [10:0] r_flags, n_flags;
    logic [20:0] r_timer, n_timer;
    logic [21:0] r_reload, n_reload;
    logic [15:0] r_mode, n_mode, r_ctrl, n_ctrl, r_baud, n_baud;
    logic [15:0] r_btick, n_btick, r_ackc, n_ackc;
    logic [7:0]  r_lastcmd, n_lastcmd;
    logic [7:0]  r_q [RxDepth];
    logic [RxIdxW-1:0] r_head, n_head;
    logic [RxCntW-1:0] r_cnt, n_cnt;
    logic [15:0] r_btn [2];
    logic [15:0] n_btn [2];
    logic [1:0]  r_pad_en, n_pad_en;
    logic [31:0] n_rd;
    logic        n_err, n_irq;

    // Push bookkeeping: up to seven bytes land in one pass.
    logic [7:0]  push_b [7];
    logic [6:0]  push_v;
    logic [RxIdxW-1:0] push_pos [7];
    logic [6:0]  push_ok;

    logic take;
    assign o_ready     = !o_valid || i_ready;
    assign take        = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        logic ev_start, ev_end, ev_tx, ev_baud, ev_rxread;
        logic [7:0] data8;
        logic [15:0] dec;
        logic [RxCntW-1:0] c;
        logic [RxCntW:0] sum;
        logic load;
        logic joy;
        ev_start = 1'b0; ev_end = 1'b0; ev_tx = 1'b0; ev_baud = 1'b0;
        ev_rxread = 1'b0; load = 1'b0;
        data8 = i_write_data[7:0];
        n_state = r_state; n_flags = r_flags; n_timer = r_timer;
        n_reload = r_reload; n_mode = r_mode; n_ctrl = r_ctrl; n_baud = r_baud;
        n_btick = r_btick; n_ackc = r_ackc; n_lastcmd = r_lastcmd;
        n_head = r_head; n_cnt = r_cnt; n_btn = r_btn; n_pad_en = r_pad_en;
        n_rd = '0; n_err = 1'b0; n_irq = 1'b0;
        joy = i_write_data[1];

        case (i_command)
            CMD_TICK: begin
                n_timer = r_timer - 21'd1;
                if (n_timer == '0) begin
                    n_timer = r_reload[20:0];
                    ev_baud = 1'b1;
                end
            end
            CMD_WRITE: begin
                case (i_reg_offset)
                    OFF_DATA: ev_tx = 1'b1;
                    OFF_MODE: n_mode = i_write_data & 16'h013f;
                    OFF_CTRL: begin
                        n_ctrl = i_write_data & 16'h3f7f;
                        n_pad_en = {i_write_data[13] && joy, !i_write_data[13] && joy};
                        ev_start = i_write_data[0] && joy && !i_write_data[2]
                                   && (r_flags & F_TXRDY2) != '0;
                        ev_end = !joy;
                    end
                    OFF_BAUD: begin
                        n_baud = i_write_data;
                        case (r_mode[1:0])
                            2'd2:    n_reload = {2'b0, i_write_data, 4'b0};
                            2'd3:    n_reload = {i_write_data, 6'b0};
                            default: n_reload = {6'b0, i_write_data};
                        endcase
                        n_timer = n_reload[20:0];
                    end
                    default: n_err = 1'b1;
                endcase
            end
            CMD_READ: begin
                case (i_reg_offset)
                    OFF_DATA: begin
                        if (r_cnt == '0) begin
                            n_rd = 32'hff;
                        end else begin
                            n_rd = {24'b0, r_q[r_head]};
                            n_head = r_head + 1'b1;
                            n_cnt = r_cnt - 1'b1;
                        end
                        ev_rxread = 1'b1;
                    end
                    OFF_STAT: n_rd = {r_timer, r_flags};
                    OFF_MODE: n_rd = {16'b0, r_mode};
                    OFF_CTRL: n_rd = {16'b0, r_ctrl};
                    OFF_BAUD: n_rd = {16'b0, r_baud};
                    default:  n_err = 1'b1;
                endcase
            end
            default: begin
                n_btn[i_pad_index][i_button_bit] = !i_pressed;
            end
        endcase

        // The transfer machine sees at most one event from one item
        // (start then end cannot both fire, as start needs joy set).
        dec = n_btick - 16'd1;
        unique case (r_state)
            ST_IDLE: if (ev_start) begin
                n_flags = n_flags | F_TXRDY1;
                n_state = ST_SESSION;
            end
            ST_SESSION: begin
                if (ev_tx) begin
                    n_btick = r_byte_dur;
                    n_flags = n_flags & ~F_TXRDY1;
                    if (r_ctrl[10]) begin
                        n_flags = n_flags | F_IRQ;
                        n_irq = 1'b1;
                    end
                    n_lastcmd = data8;
                    load = (data8 == 8'h01);
                    n_state = ST_START_SEND;
                end else if (ev_end) begin
                    n_flags = n_flags & ~F_TXRDY1;
                    n_state = ST_IDLE;
                end
            end
            ST_START_SEND: begin
                if (ev_baud) begin
                    n_btick = dec;
                    n_flags = n_flags & ~F_TXRDY2;
                    n_state = ST_SENDING;
                end else if (ev_end) begin
                    n_btick = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_SENDING: begin
                if (ev_baud) begin
                    n_btick = dec;
                    if (dec == '0) begin
                        n_btick = r_byte_dur;
                        n_flags = n_flags | F_TXRDY2;
                        n_state = ST_START_RECV;
                    end
                end else if (ev_end) begin
                    n_btick = '0;
                    n_flags = n_flags | F_TXRDY2;
                    n_state = ST_IDLE;
                end
            end
            ST_START_RECV: begin
                if (ev_baud) begin
                    n_btick = dec;
                    if (dec == '0) begin
                        if (r_cnt > 1) begin
                            n_flags = n_flags & ~F_ACKLVL;
                            n_ackc = r_ack_len;
                        end else begin
                            n_flags = n_flags | F_RXRDY;
                        end
                        if ((r_ctrl & 16'h1800) != '0) begin
                            n_flags = n_flags | F_IRQ;
                            n_irq = 1'b1;
                        end
                        n_state = ST_END_RECV;
                    end
                end else if (ev_end) begin
                    n_btick = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_END_RECV: begin
                if (ev_rxread) begin
                    n_flags = (n_flags | F_TXRDY1) & ~F_RXRDY;
                    n_state = ST_SESSION;
                end else if (ev_end) begin
                    n_flags = n_flags & ~F_RXRDY;
                    n_head = '0;
                    n_cnt = '0;
                    n_state = ST_IDLE;
                end
            end
            default: ;
        endcase

        // The acknowledge bit of a control write clears parity and interrupt.
        if (i_command == CMD_WRITE && i_reg_offset == OFF_CTRL && i_write_data[4]) begin
            n_flags = n_flags & ~(F_PARITY | F_IRQ);
        end

        // In a tick the ACK counter runs after the machine, as in the port.
        if (i_command == CMD_TICK && n_ackc != '0) begin
            n_ackc = n_ackc - 16'd1;
            if (n_ackc == '0) n_flags = n_flags | F_ACKLVL | F_RXRDY;
        end

        // Response bytes for the poll command.
        push_b[0] = 8'hff; push_b[1] = 8'h41; push_b[2] = 8'h5a;
        push_b[3] = r_btn[0][7:0]; push_b[4] = r_btn[0][15:8];
        push_b[5] = r_btn[1][7:0]; push_b[6] = r_btn[1][15:8];
        push_v = {r_pad_en[1], r_pad_en[1], r_pad_en[0], r_pad_en[0], 3'b111};
        c = r_cnt;
        for (int k = 0; k < 7; k++) begin
            sum = {1'b0, r_head} + {1'b0, c};
            push_pos[k] = sum[RxIdxW-1:0];
            push_ok[k] = load && push_v[k] && (c < RxCntW'(RxDepth));
            if (push_ok[k]) c = c + 1'b1;
        end
        if (load) n_cnt = c;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            for (int k = 0; k < 7; k++) begin
                if (push_ok[k]) r_q[push_pos[k]] <= push_b[k];
            end
            o_read_data    <= n_rd;
            o_access_error <= n_err;
            o_irq_pulse    <= n_irq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_dur <= 16'd8;
            r_ack_len  <= 16'd100;
            r_state    <= ST_IDLE;
            r_flags    <= F_TXRDY2 | F_ACKLVL;
            r_timer    <= '0;
            r_reload   <= '0;
            r_mode     <= '0;
            r_ctrl     <= '0;
            r_baud     <= '0;
            r_btick    <= '0;
            r_ackc     <= '0;
            r_lastcmd  <= '0;
            r_head     <= '0;
            r_cnt      <= '0;
            r_btn[0]   <= 16'hffff;
            r_btn[1]   <= 16'hffff;
            r_pad_en   <= '0;
            o_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_BYTE_DUR) r_byte_dur <= i_cfg_data;
                if (i_cfg_index == CFG_ACK_LEN)  r_ack_len  <= i_cfg_data;
            end
            if (take) begin
                r_state   <= n_state;
                r_flags   <= n_flags;
                r_timer   <= n_timer;
                r_reload  <= n_reload;
                r_mode    <= n_mode;
                r_ctrl    <= n_ctrl;
                r_baud    <= n_baud;
                r_btick   <= n_btick;
                r_ackc    <= n_ackc;
                r_lastcmd <= n_lastcmd;
                r_head    <= n_head;
                r_cnt     <= n_cnt;
                r_btn     <= n_btn;
                r_pad_en  <= n_pad_en;
                o_valid   <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire
